// File: hdl/pca_pkg.sv
// ============================================================================
// pca_pkg: shared types and constants for the point-to-circle angle block
// Widths of the CORDIC datapath, arctangent table in turns, pipeline depths
// and configuration register indexes.
// ============================================================================
package pca_pkg;

    // Default sizes of the coordinate and angle ports
    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 25;

    // Vectoring CORDIC: magnitudes normalized so the larger one has its
    // top bit at NORM_BIT, angle accumulated in Q0.32 turns
    localparam int CORDIC_STEPS = 28;
    localparam int NORM_BIT     = 56;
    localparam int NORM_W       = NORM_BIT + 1;
    localparam int XY_W         = NORM_W + 3;
    localparam int Z_FRAC       = 32;
    localparam int Z_W          = Z_FRAC + 2;
    localparam int Z_QUARTER    = 1 << (Z_FRAC - 2);

    // Pipeline depth: subtract, abs, three normalize stages, CORDIC, three
    // output stages
    localparam int FRONT_STAGES = 5;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY      = FRONT_STAGES + CORDIC_STEPS + BACK_STAGES;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 1'b1;

    // atan(2^-i) in Q0.32 turns
    localparam logic [Z_FRAC-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;

    // Sign and zero flags of the centred point, carried down the pipe
    typedef struct packed {
        logic dx_zero;
        logic dx_neg;
        logic dy_zero;
        logic dy_neg;
    } t_flags;

    // Magnitudes in the normalize window
    typedef struct packed {
        logic [NORM_W-1:0] ax;
        logic [NORM_W-1:0] ay;
    } t_norm;

endpackage

// File: hdl/point_to_circle_angle.sv
// ============================================================================
// point_to_circle_angle: angle of a point about a configurable circle centre
// Fully pipelined vectoring CORDIC atan2 returning a signed fraction of a turn.
// ============================================================================
// Usage:
//   Load the centre with i_cfg_we / i_cfg_idx / i_cfg_data (index 0 is
//   offset_x, index 1 is offset_y); a write takes effect at the clock edge.
//   Write only while no beat is in flight.
//   Present a point on i_point_x / i_point_y with start high; the beat is
//   taken at any edge where busy is low. busy is high only during reset.
//   The result beat appears on o_angle_turns / o_at_centre with o_valid high
//   for exactly one cycle, after the beat has passed through
//   5 front stages (subtract, abs, three normalize stages), 28 CORDIC
//   iteration stages and 3 output stages (clamp, round, quadrant map).
//   Throughput is one beat per cycle; every stage advances every cycle.
//   The receiver cannot stall, so no backpressure exists and none is needed.
//   Reset (synchronous, active low) clears both offsets and all valid bits;
//   beats in flight at reset are dropped.
// ============================================================================
module point_to_circle_angle #(
    parameter int COORD_WIDTH = pca_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = pca_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   i_point_x,
    input  logic signed [COORD_WIDTH-1:0]   i_point_y,
    input  logic                            i_cfg_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]          i_cfg_data,
    output logic                            o_valid,
    output logic signed [ANGLE_WIDTH-1:0]   o_angle_turns,
    output logic                            o_at_centre
);

    localparam int N = pca_pkg::CORDIC_STEPS;
    localparam int XPAD = pca_pkg::XY_W - pca_pkg::NORM_W;
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_HALF = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

    logic signed [COORD_WIDTH-1:0] r_offset_x, r_offset_y;
    logic                          accept;
    logic                          f_valid;
    pca_pkg::t_norm                f_norm;
    pca_pkg::t_flags               f_flags;

    logic [N:0]      c_valid;
    pca_pkg::t_xy    c_x     [N+1];
    pca_pkg::t_xy    c_y     [N+1];
    pca_pkg::t_z     c_z     [N+1];
    pca_pkg::t_flags c_flags [N+1];

    // No backpressure: hold off beats only while in reset
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // Centre registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pca_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_data;
                pca_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Subtract centre, take magnitudes, normalize
    pca_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_offset_x (r_offset_x),
        .i_offset_y (r_offset_y),
        .o_valid    (f_valid),
        .o_norm     (f_norm),
        .o_flags    (f_flags)
    );

    // Seed the CORDIC with the normalized magnitudes and a zero angle
    assign c_valid[0] = f_valid;
    assign c_x[0]     = pca_pkg::t_xy'({{XPAD{1'b0}}, f_norm.ax});
    assign c_y[0]     = pca_pkg::t_xy'({{XPAD{1'b0}}, f_norm.ay});
    assign c_z[0]     = '0;
    assign c_flags[0] = f_flags;

    // One register stage per iteration
    for (genvar i = 0; i < N; i++) begin : g_cordic
        pca_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[i]),
            .i_x     (c_x[i]),
            .i_y     (c_y[i]),
            .i_z     (c_z[i]),
            .i_flags (c_flags[i]),
            .o_valid (c_valid[i+1]),
            .o_x     (c_x[i+1]),
            .o_y     (c_y[i+1]),
            .o_z     (c_z[i+1]),
            .o_flags (c_flags[i+1])
        );
    end

    // The final residuals are not needed; only the angle moves on
    pca_back #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid[N]),
        .i_z      (c_z[N]),
        .i_flags  (c_flags[N]),
        .o_valid  (o_valid),
        .o_angle  (o_angle_turns),
        .o_centre (o_at_centre)
    );

    // Every accepted beat, and only such a beat, raises o_valid at the pipeline output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(accept, pca_pkg::LATENCY))
        else $error("result strobe does not match accepted beat");

    // A point on the centre reports a zero angle
    a_centre_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_at_centre) |-> (o_angle_turns == '0))
        else $error("centre point with nonzero angle");

    // Angle stays within half a turn either way
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_angle_turns <= ANGLE_HALF) && (o_angle_turns >= -ANGLE_HALF)))
        else $error("angle outside half a turn");

endmodule

// File: hdl/pca_front.sv
// ============================================================================
// pca_front: centre subtraction, magnitudes and normalization
// Five register stages: subtract, abs and flags, then three stages of two
// greedy normalize steps each.
// ============================================================================
module pca_front #(
    parameter int COORD_WIDTH = pca_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_offset_x,
    input  logic signed [COORD_WIDTH-1:0] i_offset_y,
    output logic                          o_valid,
    output pca_pkg::t_norm                o_norm,
    output pca_pkg::t_flags               o_flags
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PAD = pca_pkg::NORM_W - DW;

    // Shift both magnitudes left by sh if the larger one has room for it
    function automatic pca_pkg::t_norm norm_step(pca_pkg::t_norm v, int sh);
        pca_pkg::t_norm r;
        r = v;
        if (((v.ax | v.ay) >> (pca_pkg::NORM_W - sh)) == '0) begin
            r.ax = v.ax << sh;
            r.ay = v.ay << sh;
        end
        return r;
    endfunction

    logic signed [DW-1:0] r_dx, r_dy, n_dx, n_dy;
    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [DW-1:0]        r_ax, r_ay, n_ax, n_ay;
    pca_pkg::t_flags      r_f2, r_f3, r_f4, r_f5, n_f2;
    pca_pkg::t_norm       r_n3, r_n4, r_n5, n_init;

    always_comb begin
        n_dx = {i_point_x[COORD_WIDTH-1], i_point_x} - {i_offset_x[COORD_WIDTH-1], i_offset_x};
        n_dy = {i_point_y[COORD_WIDTH-1], i_point_y} - {i_offset_y[COORD_WIDTH-1], i_offset_y};
    end

    always_comb begin
        n_f2.dx_zero = (r_dx == '0);
        n_f2.dx_neg  = r_dx[DW-1];
        n_f2.dy_zero = (r_dy == '0);
        n_f2.dy_neg  = r_dy[DW-1];
        n_ax = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        n_ay = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    end

    always_comb begin
        n_init.ax = {{PAD{1'b0}}, r_ax};
        n_init.ay = {{PAD{1'b0}}, r_ay};
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_ax <= n_ax;
        r_ay <= n_ay;
        r_f2 <= n_f2;
        r_n3 <= norm_step(norm_step(n_init, 32), 16);
        r_f3 <= r_f2;
        r_n4 <= norm_step(norm_step(r_n3, 8), 4);
        r_f4 <= r_f3;
        r_n5 <= norm_step(norm_step(r_n4, 2), 1);
        r_f5 <= r_f4;
    end

    assign o_valid = r_v5;
    assign o_norm  = r_n5;
    assign o_flags = r_f5;

endmodule

// File: hdl/pca_cordic_stage.sv
// ============================================================================
// pca_cordic_stage: one vectoring CORDIC iteration
// Rotate toward the x axis by atan(2^-STEP) and register the result.
// ============================================================================
module pca_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pca_pkg::t_xy    i_x,
    input  pca_pkg::t_xy    i_y,
    input  pca_pkg::t_z     i_z,
    input  pca_pkg::t_flags i_flags,
    output logic            o_valid,
    output pca_pkg::t_xy    o_x,
    output pca_pkg::t_xy    o_y,
    output pca_pkg::t_z     o_z,
    output pca_pkg::t_flags o_flags
);

    localparam pca_pkg::t_z ATAN =
        pca_pkg::t_z'({{(pca_pkg::Z_W - pca_pkg::Z_FRAC){1'b0}}, pca_pkg::ATAN_TURNS[STEP]});

    pca_pkg::t_xy    xs, ys, n_x, n_y, r_x, r_y;
    pca_pkg::t_z     n_z, r_z;
    pca_pkg::t_flags r_flags;
    logic            y_pos, r_valid;

    always_comb begin
        xs    = i_x >>> STEP;
        ys    = i_y >>> STEP;
        y_pos = !i_y[pca_pkg::XY_W-1] && (i_y != '0);
        if (y_pos) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_flags <= i_flags;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;

endmodule

// File: hdl/pca_back.sv
// ============================================================================
// pca_back: angle rounding and quadrant mapping
// Clamp the accumulated angle, round it to the output format, then map the
// first-quadrant angle to the full circle. Three register stages.
// ============================================================================
module pca_back #(
    parameter int ANGLE_WIDTH = pca_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  pca_pkg::t_z                   i_z,
    input  pca_pkg::t_flags               i_flags,
    output logic                          o_valid,
    output logic signed [ANGLE_WIDTH-1:0] o_angle,
    output logic                          o_centre
);

    localparam int ZC_W  = pca_pkg::Z_FRAC - 1;
    localparam int DROP  = pca_pkg::Z_FRAC + 1 - ANGLE_WIDTH;
    localparam int A_W   = ANGLE_WIDTH - 1;
    localparam logic [pca_pkg::Z_FRAC-1:0] ROUND_HALF = pca_pkg::Z_FRAC'(1) << (DROP - 1);
    localparam logic [pca_pkg::Z_FRAC-1:0] QUARTER    = pca_pkg::Z_FRAC'(1) << (ANGLE_WIDTH - 3);
    localparam logic signed [ANGLE_WIDTH-1:0] HALF    = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [ANGLE_WIDTH-1:0] QTR_S   = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 3);

    logic [ZC_W-1:0]               r_zc, n_zc;
    logic [A_W-1:0]                r_a, n_a;
    logic [pca_pkg::Z_FRAC-1:0]    sum, a_full;
    logic signed [ANGLE_WIDTH-1:0] a_s, n_angle, r_angle;
    pca_pkg::t_flags               r_f1, r_f2;
    logic                          r_v1, r_v2, r_v3, r_centre;

    // Stage 1: clamp to [0, quarter turn]
    always_comb begin
        if (i_z[pca_pkg::Z_W-1]) begin
            n_zc = '0;
        end else if (i_z > pca_pkg::t_z'(pca_pkg::Z_QUARTER)) begin
            n_zc = ZC_W'(pca_pkg::Z_QUARTER);
        end else begin
            n_zc = i_z[ZC_W-1:0];
        end
    end

    // Stage 2: round half up, clamp to quarter turn
    always_comb begin
        sum    = {1'b0, r_zc} + ROUND_HALF;
        a_full = sum >> DROP;
        n_a    = (a_full > QUARTER) ? A_W'(QUARTER) : a_full[A_W-1:0];
    end

    // Stage 3: quadrant mapping
    always_comb begin
        a_s = r_f2.dy_zero ? '0 : $signed({1'b0, r_a});
        if (r_f2.dx_zero && r_f2.dy_zero) begin
            n_angle = '0;
        end else if (r_f2.dx_zero) begin
            n_angle = r_f2.dy_neg ? -QTR_S : QTR_S;
        end else if (!r_f2.dx_neg) begin
            n_angle = r_f2.dy_neg ? -a_s : a_s;
        end else begin
            n_angle = r_f2.dy_neg ? (a_s - HALF) : (HALF - a_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zc     <= n_zc;
        r_f1     <= i_flags;
        r_a      <= n_a;
        r_f2     <= r_f1;
        r_angle  <= n_angle;
        r_centre <= r_f2.dx_zero && r_f2.dy_zero;
    end

    assign o_valid  = r_v3;
    assign o_angle  = r_angle;
    assign o_centre = r_centre;

endmodule
